// ----- hdl/dftfi_pkg.sv -----
// ----------------------------------------------------------------------------
// dftfi_pkg: shared types and constants of the DFT engine
// Holds the controller-to-datapath command bundle and the Q1.14 sine table.
// ----------------------------------------------------------------------------
package dftfi_pkg;

    localparam int SAMPLE_W  = 16;  // Q2.13 sample and result width
    localparam int INDEX_W   = 4;   // width of the reported bin index
    localparam int DIV_STEPS = 16;  // quotient bits of the 1/N scaling

    // Command bundle from the controller to the datapath
    typedef struct packed {
        logic wr_en;       // write one sample beat into the store
        logic new_block;   // block complete: reset twiddle step and phase
        logic next_bin;    // advance the twiddle step to the next bin
        logic issue;       // read one sample and its twiddle
        logic first;       // this term opens a new sum
        logic post_load;   // capture the finished sums for scaling
        logic bin_last;    // captured bin closes the block
        logic post_prep;   // range check and 1/N operand setup
        logic div_step;    // reciprocal multiply for the 1/N scaling
        logic post_fin;    // form the output beat
        logic inverse;     // transform direction of the current block
    } cmd_t;

    // Quarter wave of round(16384 * sin), 17 points
    function automatic logic [14:0] quarter_sine(input logic [4:0] idx);
        logic [14:0] v;
        unique case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            5'd16:   v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Sine on a 64-step circle, Q1.14
    function automatic logic signed [15:0] sine64(input logic [5:0] step);
        logic [4:0]         idx;
        logic signed [15:0] mag;
        idx = step[4] ? (5'd16 - {1'b0, step[3:0]}) : {1'b0, step[3:0]};
        mag = $signed({1'b0, quarter_sine(idx)});
        return step[5] ? -mag : mag;
    endfunction

endpackage

// ----- hdl/dftfi_ram.sv -----
// ----------------------------------------------------------------------------
// dftfi_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dftfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/dftfi_ctrl.sv -----
// ----------------------------------------------------------------------------
// dftfi_ctrl: sequencing of load, accumulate and scaling
// Main FSM walks load, per-bin accumulation and handoff; a second FSM runs
// the scaling steps and the output beat.
// ----------------------------------------------------------------------------
module dftfi_ctrl #(
    parameter int POINTS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_inverse_mode,
    input  logic                      s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output dftfi_pkg::cmd_t           cmd,
    output logic [$clog2(POINTS)-1:0] wr_addr,
    output logic [$clog2(POINTS)-1:0] rd_addr,
    output logic [$clog2(POINTS)-1:0] bin_idx
);

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HAND  = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        PS_IDLE = 5'b00001,
        PS_PREP = 5'b00010,
        PS_DIV  = 5'b00100,
        PS_FIN  = 5'b01000,
        PS_HOLD = 5'b10000
    } post_state_t;

    state_t      state_reg, state_next;
    post_state_t ps_reg, ps_next;

    logic [IDX_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             drain_reg, drain_next;
    logic             inv_cfg_reg, inv_cfg_next;
    logic             inv_blk_reg, inv_blk_next;

    logic load_beat;
    logic post_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = (ps_reg == PS_HOLD);
    assign load_beat = s_valid && s_ready;
    assign post_load = (state_reg == ST_HAND) && (ps_reg == PS_IDLE);

    assign wr_addr = wr_cnt_reg;
    assign rd_addr = n_reg;
    assign bin_idx = k_reg;

    always_comb begin
        cmd           = '0;
        cmd.wr_en     = load_beat;
        cmd.new_block = load_beat && (wr_cnt_reg == LAST_IDX);
        cmd.issue     = (state_reg == ST_MAC);
        cmd.first     = (n_reg == '0);
        cmd.post_load = post_load;
        cmd.bin_last  = (k_reg == LAST_IDX);
        cmd.next_bin  = post_load && (k_reg != LAST_IDX);
        cmd.post_prep = (ps_reg == PS_PREP);
        cmd.div_step  = (ps_reg == PS_DIV);
        cmd.post_fin  = (ps_reg == PS_FIN);
        cmd.inverse   = inv_blk_reg;
    end

    // Main sequencer
    always_comb begin
        state_next   = state_reg;
        wr_cnt_next  = wr_cnt_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        drain_next   = drain_reg;
        inv_cfg_next = cfg_valid ? cfg_inverse_mode : inv_cfg_reg;
        inv_blk_next = inv_blk_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (load_beat) begin
                    if (wr_cnt_reg == LAST_IDX) begin
                        wr_cnt_next  = '0;
                        n_next       = '0;
                        k_next       = '0;
                        inv_blk_next = inv_cfg_reg;
                        state_next   = ST_MAC;
                    end else begin
                        wr_cnt_next = wr_cnt_reg + 1'b1;
                    end
                end
            end
            ST_MAC: begin
                if (n_reg == LAST_IDX) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    n_next = n_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_HAND;
                end
            end
            ST_HAND: begin
                if (post_load) begin
                    if (k_reg == LAST_IDX) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        n_next     = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Scaling and output sequencer
    always_comb begin
        ps_next = ps_reg;
        unique case (ps_reg)
            PS_IDLE: begin
                if (post_load) begin
                    ps_next = PS_PREP;
                end
            end
            PS_PREP: ps_next = inv_blk_reg ? PS_FIN : PS_DIV;
            PS_DIV:  ps_next = PS_FIN;
            PS_FIN:  ps_next = PS_HOLD;
            PS_HOLD: begin
                if (m_ready) begin
                    ps_next = PS_IDLE;
                end
            end
            default: ps_next = PS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            ps_reg      <= PS_IDLE;
            wr_cnt_reg  <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            drain_reg   <= 1'b0;
            inv_cfg_reg <= 1'b0;
            inv_blk_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ps_reg      <= ps_next;
            wr_cnt_reg  <= wr_cnt_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            drain_reg   <= drain_next;
            inv_cfg_reg <= inv_cfg_next;
            inv_blk_reg <= inv_blk_next;
        end
    end

endmodule

// ----- hdl/dftfi_datapath.sv -----
// ----------------------------------------------------------------------------
// dftfi_datapath: sample store, twiddle phase, complex MAC and scaling
// Three-stage MAC followed by a reciprocal-multiply 1/N scaling in forward mode.
// ----------------------------------------------------------------------------
module dftfi_datapath #(
    parameter int POINTS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  dftfi_pkg::cmd_t                         cmd,
    input  logic [$clog2(POINTS)-1:0]               wr_addr,
    input  logic [$clog2(POINTS)-1:0]               rd_addr,
    input  logic [$clog2(POINTS)-1:0]               bin_idx,
    input  logic signed [dftfi_pkg::SAMPLE_W-1:0]   s_in_re,
    input  logic signed [dftfi_pkg::SAMPLE_W-1:0]   s_in_im,
    output logic signed [dftfi_pkg::SAMPLE_W-1:0]   m_out_re,
    output logic signed [dftfi_pkg::SAMPLE_W-1:0]   m_out_im,
    output logic [dftfi_pkg::INDEX_W-1:0]           m_out_index,
    output logic                                    m_out_last
);

    localparam int SW    = dftfi_pkg::SAMPLE_W;
    localparam int IDX_W = $clog2(POINTS);
    localparam int ACC_W = 34 + IDX_W;
    localparam int UW    = ACC_W + 1 - 14;
    localparam int VW    = dftfi_pkg::DIV_STEPS + IDX_W;
    // floor(v / N) = (v * RECIP) >> RECIP_SH, exact for every v below 2**VW
    localparam int     RECIP_SH = VW + IDX_W;
    localparam longint RECIP_L  =
        ((longint'(1) <<< RECIP_SH) + longint'(POINTS) - 1) / longint'(POINTS);
    localparam logic [VW:0] RECIP = (VW + 1)'(RECIP_L);

    localparam logic [IDX_W-1:0]   HALF_P = IDX_W'(POINTS / 2);
    localparam logic [IDX_W-1:0]   R64    = IDX_W'(64 % POINTS);
    localparam logic [5:0]         Q64    = 6'((64 / POINTS) % 64);
    localparam logic [IDX_W:0]     P_EXT  = (IDX_W + 1)'(POINTS);
    localparam logic signed [ACC_W:0] HALF_FWD = (ACC_W + 1)'(POINTS * 8192);
    localparam logic signed [ACC_W:0] HALF_INV = (ACC_W + 1)'(8192);
    localparam logic signed [UW-1:0]  FWD_HI   = UW'(32768 * POINTS);
    localparam logic signed [UW-1:0]  FWD_LO   = UW'(-32768 * POINTS);
    localparam logic signed [UW-1:0]  INV_HI   = UW'(32767);
    localparam logic signed [UW-1:0]  INV_LO   = UW'(-32768);
    localparam logic signed [SW-1:0]  SAT_MAX  = SW'(32767);
    localparam logic signed [SW-1:0]  SAT_MIN  = SW'(-32768);

    // ---- sample store ----
    logic [2*SW-1:0] rd_data;
    logic signed [SW-1:0] rd_re, rd_im;

    dftfi_ram #(
        .WIDTH (2 * SW),
        .DEPTH (POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata ({s_in_im, s_in_re}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_re = $signed(rd_data[SW-1:0]);
    assign rd_im = $signed(rd_data[2*SW-1:SW]);

    // ---- twiddle phase: circle step plus remainder of k*n*64 + N/2 over N ----
    logic [5:0]       step_reg, dq_reg;
    logic [IDX_W-1:0] rem_ph_reg, dr_reg;
    logic [IDX_W:0]   ph_sum, dr_sum;
    logic             ph_carry, dr_carry;

    assign ph_sum   = {1'b0, rem_ph_reg} + {1'b0, dr_reg};
    assign ph_carry = (ph_sum >= P_EXT);
    assign dr_sum   = {1'b0, dr_reg} + {1'b0, R64};
    assign dr_carry = (dr_sum >= P_EXT);

    always_ff @(posedge aclk) begin
        if (cmd.new_block) begin
            dq_reg     <= '0;
            dr_reg     <= '0;
            step_reg   <= '0;
            rem_ph_reg <= HALF_P;
        end else if (cmd.next_bin) begin
            dq_reg     <= dq_reg + Q64 + 6'(dr_carry);
            dr_reg     <= dr_carry ? IDX_W'(dr_sum - P_EXT) : IDX_W'(dr_sum);
            step_reg   <= '0;
            rem_ph_reg <= HALF_P;
        end else if (cmd.issue) begin
            step_reg   <= step_reg + dq_reg + 6'(ph_carry);
            rem_ph_reg <= ph_carry ? IDX_W'(ph_sum - P_EXT) : IDX_W'(ph_sum);
        end
    end

    // ---- MAC pipeline ----
    logic signed [SW-1:0] sin1_reg, cos1_reg;
    logic                 v1_reg, first1_reg;
    logic signed [31:0]   pc2_reg, ps2_reg;
    logic                 v2_reg, first2_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0] term_re, term_im;

    always_ff @(posedge aclk) begin
        sin1_reg   <= dftfi_pkg::sine64(step_reg);
        cos1_reg   <= dftfi_pkg::sine64(step_reg + 6'd16);
        first1_reg <= cmd.first;
        pc2_reg    <= rd_re * cos1_reg;
        ps2_reg    <= (cmd.inverse ? rd_im : rd_re) * sin1_reg;
        first2_reg <= first1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_comb begin
        term_re = cmd.inverse ? (ACC_W'(pc2_reg) - ACC_W'(ps2_reg)) : ACC_W'(pc2_reg);
        term_im = -ACC_W'(ps2_reg);
    end

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_re_reg <= first2_reg ? term_re : acc_re_reg + term_re;
            acc_im_reg <= first2_reg ? term_im : acc_im_reg + term_im;
        end
    end

    // ---- scaling: round, range check, divide by N (forward) ----
    logic signed [ACC_W:0]  half, t_re, t_im;
    logic signed [UW-1:0]   u_re_reg, u_im_reg;
    logic signed [UW-1:0]   v_re, v_im;
    logic                   hi_re_reg, lo_re_reg, hi_im_reg, lo_im_reg;
    logic [VW-1:0]          vq_re_reg, vq_im_reg;
    logic [2*VW:0]          prod_re, prod_im;
    logic [SW-1:0]          quo_re_reg, quo_im_reg;
    logic [dftfi_pkg::INDEX_W-1:0] idx_reg;
    logic                   last_reg;
    logic signed [SW-1:0]   out_re_reg, out_im_reg;

    assign half = cmd.inverse ? HALF_INV : HALF_FWD;
    assign t_re = $signed({acc_re_reg[ACC_W-1], acc_re_reg}) + half;
    assign t_im = $signed({acc_im_reg[ACC_W-1], acc_im_reg}) + half;
    assign v_re = u_re_reg - FWD_LO;
    assign v_im = u_im_reg - FWD_LO;

    assign prod_re = (2*VW+1)'(vq_re_reg) * (2*VW+1)'(RECIP);
    assign prod_im = (2*VW+1)'(vq_im_reg) * (2*VW+1)'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.post_load) begin
            u_re_reg <= t_re[ACC_W:14];
            u_im_reg <= t_im[ACC_W:14];
            idx_reg  <= dftfi_pkg::INDEX_W'(bin_idx);
            last_reg <= cmd.bin_last;
        end
        if (cmd.post_prep) begin
            if (cmd.inverse) begin
                hi_re_reg  <= (u_re_reg > INV_HI);
                lo_re_reg  <= (u_re_reg < INV_LO);
                quo_re_reg <= u_re_reg[SW-1:0];
            end else begin
                hi_re_reg  <= (u_re_reg >= FWD_HI);
                lo_re_reg  <= (u_re_reg < FWD_LO);
            end
            hi_im_reg <= (u_im_reg >= FWD_HI);
            lo_im_reg <= (u_im_reg < FWD_LO);
            vq_re_reg <= v_re[VW-1:0];
            vq_im_reg <= v_im[VW-1:0];
        end else if (cmd.div_step) begin
            quo_re_reg <= prod_re[RECIP_SH +: SW];
            quo_im_reg <= prod_im[RECIP_SH +: SW];
        end
        if (cmd.post_fin) begin
            // the forward quotient is biased by 32768: flip its top bit
            if (hi_re_reg) begin
                out_re_reg <= SAT_MAX;
            end else if (lo_re_reg) begin
                out_re_reg <= SAT_MIN;
            end else if (cmd.inverse) begin
                out_re_reg <= $signed(quo_re_reg);
            end else begin
                out_re_reg <= $signed({~quo_re_reg[SW-1], quo_re_reg[SW-2:0]});
            end
            if (cmd.inverse) begin
                out_im_reg <= '0;
            end else if (hi_im_reg) begin
                out_im_reg <= SAT_MAX;
            end else if (lo_im_reg) begin
                out_im_reg <= SAT_MIN;
            end else begin
                out_im_reg <= $signed({~quo_im_reg[SW-1], quo_im_reg[SW-2:0]});
            end
        end
    end

    assign m_out_re    = out_re_reg;
    assign m_out_im    = out_im_reg;
    assign m_out_index = idx_reg;
    assign m_out_last  = last_reg;

endmodule

// ----- hdl/dft_engine_forward_inverse.sv -----
// ----------------------------------------------------------------------------
// dft_engine_forward_inverse: direct-sum DFT engine, forward and inverse
// Load takes one sample beat per cycle; a block of POINTS beats starts the sums.
// The bins take the shared MAC in turn; scaling (prep, reciprocal multiply in
// forward mode only, then format) overlaps the next bin, which waits in handoff
// until the scaling sequencer is idle, so a held output beat stalls the sums.
// Reset empties the block and selects forward mode.
// ----------------------------------------------------------------------------
module dft_engine_forward_inverse #(
    parameter int POINTS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel: one register, inverse_mode
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_inverse_mode,
    // sample input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dftfi_pkg::SAMPLE_W-1:0] s_in_re,
    input  logic signed [dftfi_pkg::SAMPLE_W-1:0] s_in_im,
    // result output channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dftfi_pkg::SAMPLE_W-1:0] m_out_re,
    output logic signed [dftfi_pkg::SAMPLE_W-1:0] m_out_im,
    output logic [dftfi_pkg::INDEX_W-1:0]         m_out_index,
    output logic                                  m_out_last
);

    // Structure:
    //   - the controller counts load beats, walks bin k and term n, and
    //     runs a separate scaling sequencer that owns the output beat
    //   - the datapath keeps the sample store (one RAM, one write and one
    //     registered read per cycle), the twiddle phase, the complex MAC
    //     and the rounding, saturation and 1/N reciprocal multiply
    // Twiddle phase advances by k*64/N circle steps per term, kept as an
    // integer step plus a remainder below N, so no divider sits in the loop.
    // The output register holds its beat while the next bin accumulates;
    // a new bin is handed over only once the scaling stage is free.

    localparam int IDX_W = $clog2(POINTS);

    dftfi_pkg::cmd_t  cmd;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] bin_idx;

    dftfi_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_inverse_mode (cfg_inverse_mode),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .wr_addr          (wr_addr),
        .rd_addr          (rd_addr),
        .bin_idx          (bin_idx)
    );

    dftfi_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .bin_idx     (bin_idx),
        .s_in_re     (s_in_re),
        .s_in_im     (s_in_im),
        .m_out_re    (m_out_re),
        .m_out_im    (m_out_im),
        .m_out_index (m_out_index),
        .m_out_last  (m_out_last)
    );

endmodule
